FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL file that carries checks, the top level.
// Needs nothing else; each macro takes clock, active-low reset and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PVA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PVA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/pva_pkg.sv
// Shared constants, types and helpers of the voice allocator.
// Used by the channel interfaces and every module of the block.
package pva_pkg;

  localparam int VOICES   = 8;
  localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VOICE_W  = 3;
  localparam int NOTE_W   = 7;
  localparam int VEL_W    = 7;
  localparam int TIME_W   = 32;

  localparam logic KIND_NOTE_ON  = 1'b0;
  localparam logic KIND_NOTE_OFF = 1'b1;

  typedef enum logic [1:0] {
    ACT_IGNORE  = 2'd0,
    ACT_START   = 2'd1,
    ACT_STEAL   = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef logic [VIDX_W-1:0] vidx_t;

  // One voice as seen on the table read port.
  typedef struct packed {
    logic              active;
    logic [NOTE_W-1:0] note;
    logic [TIME_W-1:0] start_time;
  } entry_t;

  // Table write request.
  typedef struct packed {
    logic              en;
    logic              set_active;
    vidx_t             idx;
    logic [NOTE_W-1:0] note;
    logic [TIME_W-1:0] start_time;
  } tbl_wr_t;

  // Running results of the voice scan.
  typedef struct packed {
    logic              free_found;
    vidx_t             free_idx;
    logic              hold_found;
    vidx_t             hold_idx;
    vidx_t             old_idx;
    logic [TIME_W-1:0] old_time;
    logic [NOTE_W-1:0] old_note;
  } scan_acc_t;

  // Low bits of a voice index, zero-extended when the index is narrow.
  function automatic logic [VOICE_W-1:0] voice_field(input vidx_t idx);
    logic [VIDX_W+VOICE_W-1:0] wide;
    wide = (VIDX_W + VOICE_W)'(idx);
    return wide[VOICE_W-1:0];
  endfunction

endpackage

FILE: rtl/core/pva_in_if.sv
// Event input channel: valid/ready handshake and the note event word.
// Depends on pva_pkg for field widths.
interface pva_in_if import pva_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [NOTE_W-1:0] note;
  logic [VEL_W-1:0]  velocity;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, kind, note, velocity, now_ms, input ready);
  modport sink   (input valid, kind, note, velocity, now_ms, output ready);
endinterface

FILE: rtl/core/pva_out_if.sv
// Result channel: valid/ready handshake and the allocation result word.
// Depends on pva_pkg for field widths and the action code.
interface pva_out_if import pva_pkg::*; ();
  logic               valid;
  logic               ready;
  action_t            action;
  logic [VOICE_W-1:0] voice;
  logic [NOTE_W-1:0]  note_out;
  logic [VEL_W-1:0]   velocity_out;
  logic [NOTE_W-1:0]  stolen_note;

  modport source (output valid, action, voice, note_out, velocity_out, stolen_note,
                  input ready);
  modport sink   (input valid, action, voice, note_out, velocity_out, stolen_note,
                  output ready);
endinterface

FILE: rtl/core/pva_voice_table.sv
// Voice table: active bits with reset, note and start time per voice.
// One read index, one write port. Depends on pva_pkg.
module pva_voice_table import pva_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  vidx_t   rd_idx,
  output entry_t  rd_entry,
  input  tbl_wr_t wr
);

  logic [VOICES-1:0] active_r;
  logic [NOTE_W-1:0] note_r [VOICES];
  logic [TIME_W-1:0] time_r [VOICES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (wr.en) begin
      active_r[wr.idx] <= wr.set_active;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.set_active) begin
      note_r[wr.idx] <= wr.note;
      time_r[wr.idx] <= wr.start_time;
    end
  end

  always_comb begin
    rd_entry.active     = active_r[rd_idx];
    rd_entry.note       = note_r[rd_idx];
    rd_entry.start_time = time_r[rd_idx];
  end

endmodule

FILE: rtl/core/pva_scan_step.sv
// Shared scan unit: folds one voice into the running scan results.
// Finds first free, first holding the key note, and oldest start time.
// Depends on pva_pkg.
module pva_scan_step import pva_pkg::*; (
  input  scan_acc_t         acc,
  input  entry_t            entry,
  input  vidx_t             idx,
  input  logic [NOTE_W-1:0] key_note,
  input  logic              first,
  output scan_acc_t         acc_nxt
);

  scan_acc_t base;

  always_comb begin
    base = acc;
    if (first) begin
      base.free_found = 1'b0;
      base.hold_found = 1'b0;
      base.old_idx    = idx;
      base.old_time   = entry.start_time;
      base.old_note   = entry.note;
    end

    acc_nxt = base;
    if (!entry.active && !base.free_found) begin
      acc_nxt.free_found = 1'b1;
      acc_nxt.free_idx   = idx;
    end
    if (entry.active && (entry.note == key_note) && !base.hold_found) begin
      acc_nxt.hold_found = 1'b1;
      acc_nxt.hold_idx   = idx;
    end
    // strict less-than keeps ties on the lower index
    if (!first && (entry.start_time < base.old_time)) begin
      acc_nxt.old_idx  = idx;
      acc_nxt.old_time = entry.start_time;
      acc_nxt.old_note = entry.note;
    end
  end

endmodule

FILE: rtl/core/pva_ctrl.sv
// Sequencer: takes an event word, scans the voices one per cycle through
// the shared scan unit, updates the table and registers the result word.
// Depends on pva_pkg, pva_in_if, pva_out_if and pva_scan_step.
module pva_ctrl import pva_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_ch,
  pva_out_if.source out_ch,
  output vidx_t     rd_idx,
  input  entry_t    rd_entry,
  output tbl_wr_t   wr
);

  state_t             state_r, state_nxt;
  vidx_t              scan_idx_r, scan_idx_nxt;
  scan_acc_t          acc_r, acc_nxt, step_out;
  logic               kind_r, kind_nxt;
  logic [NOTE_W-1:0]  note_r, note_nxt;
  logic [VEL_W-1:0]   vel_r, vel_nxt;
  logic [TIME_W-1:0]  time_r, time_nxt;
  logic               out_valid_r, out_valid_nxt;
  action_t            action_r, action_nxt;
  logic [VOICE_W-1:0] voice_r, voice_nxt;
  logic [NOTE_W-1:0]  note_out_r, note_out_nxt;
  logic [VEL_W-1:0]   vel_out_r, vel_out_nxt;
  logic [NOTE_W-1:0]  stolen_r, stolen_nxt;
  vidx_t              pick;

  pva_scan_step u_step (
    .acc      (acc_r),
    .entry    (rd_entry),
    .idx      (scan_idx_r),
    .key_note (note_r),
    .first    (scan_idx_r == '0),
    .acc_nxt  (step_out)
  );

  assign rd_idx      = scan_idx_r;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = action_r;
  assign out_ch.voice        = voice_r;
  assign out_ch.note_out     = note_out_r;
  assign out_ch.velocity_out = vel_out_r;
  assign out_ch.stolen_note  = stolen_r;

  always_comb begin
    state_nxt     = state_r;
    scan_idx_nxt  = scan_idx_r;
    acc_nxt       = acc_r;
    kind_nxt      = kind_r;
    note_nxt      = note_r;
    vel_nxt       = vel_r;
    time_nxt      = time_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    action_nxt    = action_r;
    voice_nxt     = voice_r;
    note_out_nxt  = note_out_r;
    vel_out_nxt   = vel_out_r;
    stolen_nxt    = stolen_r;
    wr            = '0;
    pick          = acc_r.free_found ? acc_r.free_idx : acc_r.old_idx;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt     = in_ch.kind;
          note_nxt     = in_ch.note;
          vel_nxt      = in_ch.velocity;
          time_nxt     = in_ch.now_ms;
          scan_idx_nxt = '0;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        acc_nxt = step_out;
        if (scan_idx_r == VIDX_W'(VOICES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (kind_r == KIND_NOTE_ON) begin
            wr.en         = 1'b1;
            wr.set_active = 1'b1;
            wr.idx        = pick;
            wr.note       = note_r;
            wr.start_time = time_r;
            action_nxt    = acc_r.free_found ? ACT_START : ACT_STEAL;
            voice_nxt     = voice_field(pick);
            note_out_nxt  = note_r;
            vel_out_nxt   = vel_r;
            stolen_nxt    = acc_r.free_found ? '0 : acc_r.old_note;
          end else if (acc_r.hold_found) begin
            wr.en         = 1'b1;
            wr.set_active = 1'b0;
            wr.idx        = acc_r.hold_idx;
            action_nxt    = ACT_RELEASE;
            voice_nxt     = voice_field(acc_r.hold_idx);
            note_out_nxt  = note_r;
            vel_out_nxt   = '0;
            stolen_nxt    = '0;
          end else begin
            action_nxt   = ACT_IGNORE;
            voice_nxt    = '0;
            note_out_nxt = '0;
            vel_out_nxt  = '0;
            stolen_nxt   = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_idx_r  <= scan_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    kind_r     <= kind_nxt;
    note_r     <= note_nxt;
    vel_r      <= vel_nxt;
    time_r     <= time_nxt;
    action_r   <= action_nxt;
    voice_r    <= voice_nxt;
    note_out_r <= note_out_nxt;
    vel_out_r  <= vel_out_nxt;
    stolen_r   <= stolen_nxt;
  end

endmodule

FILE: rtl/core/poly_voice_allocator.sv
// Channel   Dir  Handshake     Word
// in_ch     in   valid/ready   kind, note, velocity, now_ms
// out_ch    out  valid/ready   action, voice, note_out, velocity_out, stolen_note
//
// An event is handled in steps: the word is taken, each voice in turn goes
// through the shared scan unit, then the table is updated and the result
// register loaded. in_ch.ready is high only while the sequencer is idle;
// a result waiting on out_ch does not block taking the next event, but the
// table update of that event stalls until the result register is free.
// Synchronous active-low reset clears all voices to inactive.
// Top level of the voice allocator; depends on pva_pkg, the channel interfaces,
// pva_voice_table, pva_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module poly_voice_allocator import pva_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_ch,
  pva_out_if.source out_ch
);

  vidx_t   rd_idx;
  entry_t  rd_entry;
  tbl_wr_t wr;

  pva_voice_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  pva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .wr       (wr)
  );

  `PVA_ASSERT_NXT(a_busy_after_take, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after taking an event")
  `PVA_ASSERT_IMP(a_ignore_zero, clk, rst_n, out_ch.valid && (out_ch.action == ACT_IGNORE), (out_ch.voice == '0) && (out_ch.note_out == '0), "ignored note off carries voice or note")
  `PVA_ASSERT_IMP(a_off_no_vel, clk, rst_n, out_ch.valid && ((out_ch.action == ACT_IGNORE) || (out_ch.action == ACT_RELEASE)), (out_ch.velocity_out == '0) && (out_ch.stolen_note == '0), "note off result carries velocity or stolen note")

endmodule

FILE: tb/poly_voice_allocator_tb.sv
`timescale 1ns / 100ps
// Testbench for poly_voice_allocator: drives note events, predicts each allocation word
// from a local voice table and checks every result word field by field.
// Depends on pva_pkg, pva_in_if, pva_out_if and the RTL of the block.
module poly_voice_allocator_tb;
  import pva_pkg::*;

  localparam int RANDOM_EVENTS = 1750;
  localparam int IDLE_LIMIT    = 2000;

  typedef struct packed {
    logic              kind;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  velocity;
    logic [TIME_W-1:0] now_ms;
  } note_event_t;

  typedef struct packed {
    action_t            action;
    logic [VOICE_W-1:0] voice;
    logic [NOTE_W-1:0]  note_out;
    logic [VEL_W-1:0]   velocity_out;
    logic [NOTE_W-1:0]  stolen_note;
  } alloc_word_t;

  logic clk;
  logic rst_n;

  pva_in_if  ev_if ();
  pva_out_if res_if ();

  poly_voice_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (ev_if),
    .out_ch (res_if)
  );

  note_event_t pending_events[$];
  alloc_word_t expected_allocs[$];

  // Voice table as the block should hold it.
  logic              voice_on[VOICES];
  logic [NOTE_W-1:0] voice_note[VOICES];
  logic [TIME_W-1:0] voice_start[VOICES];

  logic ev_sent   = 1'b0;
  int   send_gap  = 0;
  int   stall_left = 0;
  logic steady_tx = 1'b0;
  logic steady_rx = 1'b0;
  int   errors    = 0;
  int   n_start   = 0;
  int   n_steal   = 0;
  int   n_release = 0;
  int   n_ignore  = 0;
  int   idle_cycles = 0;

  always #4 clk = ~clk;

  // Apply one event to the voice table and return the word the block should send.
  function automatic alloc_word_t allocate_voice(note_event_t ev);
    alloc_word_t w;
    int          v;
    logic [31:0] vi;
    w = '0;
    v = -1;
    if (ev.kind == KIND_NOTE_ON) begin
      for (int i = VOICES - 1; i >= 0; i--)
        if (!voice_on[i]) v = i;
      if (v < 0) begin
        // all busy: steal the earliest start, ties to the lowest voice
        v = 0;
        for (int i = 1; i < VOICES; i++)
          if (voice_start[i] < voice_start[v]) v = i;
        w.action      = ACT_STEAL;
        w.stolen_note = voice_note[v];
      end else begin
        w.action = ACT_START;
      end
      voice_on[v]    = 1'b1;
      voice_note[v]  = ev.note;
      voice_start[v] = ev.now_ms;
      w.note_out     = ev.note;
      w.velocity_out = ev.velocity;
    end else begin
      for (int i = VOICES - 1; i >= 0; i--)
        if (voice_on[i] && voice_note[i] == ev.note) v = i;
      if (v < 0) begin
        w.action = ACT_IGNORE;
      end else begin
        voice_on[v] = 1'b0;
        w.action    = ACT_RELEASE;
        w.note_out  = ev.note;
      end
    end
    vi = (v < 0) ? 32'd0 : 32'(v);
    w.voice = vi[VOICE_W-1:0];
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic queue_event(input logic kind, input int note, input int vel,
                             input logic [TIME_W-1:0] now);
    note_event_t ev;
    ev.kind     = kind;
    ev.note     = NOTE_W'(note);
    ev.velocity = VEL_W'(vel);
    ev.now_ms   = now;
    pending_events.push_back(ev);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Event driver: present the next word at the falling edge, hold it until taken.
  always @(negedge clk) begin
    note_event_t ev;
    if (!rst_n) begin
      ev_if.valid <= 1'b0;
    end else if (!ev_if.valid || ev_sent) begin
      if (ev_sent) begin
        if ($urandom_range(0, 149) == 0) steady_tx = !steady_tx;
        send_gap = (steady_tx || $urandom_range(0, 2) == 0) ? 0 : pick_gap();
      end
      if (send_gap > 0 || pending_events.size() == 0) begin
        if (send_gap > 0) send_gap--;
        ev_if.valid <= 1'b0;
      end else begin
        ev = pending_events.pop_front();
        ev_if.kind     <= ev.kind;
        ev_if.note     <= ev.note;
        ev_if.velocity <= ev.velocity;
        ev_if.now_ms   <= ev.now_ms;
        ev_if.valid    <= 1'b1;
      end
    end
  end

  // Result sink: stall ready at random, with calm stretches.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 299) == 0) steady_rx = !steady_rx;
      if (stall_left == 0 && !steady_rx && $urandom_range(0, 5) == 0)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on every taken event, check every taken result word.
  always @(posedge clk) begin
    note_event_t ev;
    alloc_word_t got;
    alloc_word_t want;
    logic        res_taken;
    ev_sent   = rst_n && ev_if.valid && ev_if.ready;
    res_taken = rst_n && res_if.valid && res_if.ready;
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) voice_on[i] = 1'b0;
      idle_cycles = 0;
    end else begin
      if (ev_sent) begin
        ev = '{ev_if.kind, ev_if.note, ev_if.velocity, ev_if.now_ms};
        expected_allocs.push_back(allocate_voice(ev));
      end
      if (res_taken) begin
        got = '{res_if.action, res_if.voice, res_if.note_out, res_if.velocity_out,
                res_if.stolen_note};
        if (expected_allocs.size() == 0) begin
          errors++;
          $error("result word with no event pending: action %0d voice %0d",
                 got.action, got.voice);
        end else begin
          want = expected_allocs.pop_front();
          check_field("action", want.action, got.action);
          check_field("voice", want.voice, got.voice);
          check_field("note_out", want.note_out, got.note_out);
          check_field("velocity_out", want.velocity_out, got.velocity_out);
          check_field("stolen_note", want.stolen_note, got.stolen_note);
          case (want.action)
            ACT_START:   n_start++;
            ACT_STEAL:   n_steal++;
            ACT_RELEASE: n_release++;
            default:     n_ignore++;
          endcase
        end
      end
      if (ev_sent || res_taken) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [TIME_W-1:0] clock_ms;
    logic [NOTE_W-1:0] sounding[$];
    logic [NOTE_W-1:0] pick;
    int                on_bias;
    int                r;
    int                k;
    clk             = 1'b0;
    rst_n           = 1'b0;
    ev_if.valid     = 1'b0;
    ev_if.kind      = KIND_NOTE_ON;
    ev_if.note      = '0;
    ev_if.velocity  = '0;
    ev_if.now_ms    = '0;
    res_if.ready    = 1'b0;

    // Directed: stray off on an empty table, extremes, duplicate notes, reuse,
    // steals with ties and wrapped time stamps, off on a stale entry.
    queue_event(KIND_NOTE_OFF, 5, 90, 32'd3);
    queue_event(KIND_NOTE_ON, 0, 0, 32'd0);
    queue_event(KIND_NOTE_ON, 127, 127, 32'hFFFF_FFFF);
    queue_event(KIND_NOTE_ON, 60, 64, 32'd100);
    queue_event(KIND_NOTE_ON, 60, 1, 32'd100);
    queue_event(KIND_NOTE_OFF, 60, 0, 32'd100);
    queue_event(KIND_NOTE_ON, 61, 2, 32'd100);
    for (int i = 62; i <= 65; i++) queue_event(KIND_NOTE_ON, i, i, 32'd100);
    queue_event(KIND_NOTE_ON, 70, 10, 32'd5);
    queue_event(KIND_NOTE_ON, 71, 11, 32'd7);
    queue_event(KIND_NOTE_ON, 72, 12, 32'd200);
    queue_event(KIND_NOTE_ON, 73, 13, 32'd300);
    queue_event(KIND_NOTE_ON, 74, 14, 32'd300);
    queue_event(KIND_NOTE_OFF, 127, 127, 32'd301);
    queue_event(KIND_NOTE_OFF, 127, 127, 32'd302);
    queue_event(KIND_NOTE_ON, 0, 127, 32'h8000_0000);
    queue_event(KIND_NOTE_OFF, 0, 127, 32'h8000_0001);
    queue_event(KIND_NOTE_OFF, 60, 33, 32'h8000_0002);
    queue_event(KIND_NOTE_ON, 75, 85, 32'hFFFF_FFFE);
    queue_event(KIND_NOTE_ON, 76, 86, 32'd1);
    queue_event(KIND_NOTE_ON, 77, 87, 32'd0);

    // Random: mostly note-ons and matching note-offs over a narrow band of notes,
    // with stray note-offs and time jumps mixed in.
    clock_ms = $urandom();
    on_bias  = 50;
    for (int n = 0; n < RANDOM_EVENTS; n++) begin
      if (n % 200 == 0) on_bias = $urandom_range(30, 70);
      r = $urandom_range(0, 99);
      k = $urandom_range(0, 99);
      // hold the clock on some events to force start-time ties
      if (k < 75) clock_ms = clock_ms + $urandom_range(1, 60);
      else if (k >= 85 && k < 95) clock_ms = $urandom();
      else if (k >= 95) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 8);
      if (r < on_bias) begin
        if ($urandom_range(0, 3) != 0) pick = NOTE_W'(48 + $urandom_range(0, 15));
        else pick = NOTE_W'($urandom_range(0, 127));
        sounding.push_back(pick);
        if (sounding.size() > 2 * VOICES) void'(sounding.pop_front());
        queue_event(KIND_NOTE_ON, pick, $urandom_range(0, 127), clock_ms);
      end else if (r < 92 && sounding.size() > 0) begin
        k = $urandom_range(0, sounding.size() - 1);
        pick = sounding[k];
        sounding.delete(k);
        queue_event(KIND_NOTE_OFF, pick, $urandom_range(0, 127), clock_ms);
      end else begin
        queue_event(KIND_NOTE_OFF, $urandom_range(0, 127), $urandom_range(0, 127), clock_ms);
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending_events.size() != 0 || ev_if.valid) @(negedge clk);
    while (expected_allocs.size() != 0) @(negedge clk);
    repeat (4 * (VOICES + 2)) @(negedge clk);

    $display("checked %0d result words: %0d free starts, %0d steals, %0d releases,",
             n_start + n_steal + n_release + n_ignore, n_start, n_steal, n_release);
    $display("%0d ignored note-offs, %0d field mismatches", n_ignore, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
